[rtl/dsfw_pkg.sv]
// Package for the DAC serial frame writer: command codes, frame constants,
// and the fixed-point constants for the millivolt to code conversion. No dependencies.
`default_nettype none

package dsfw_pkg;

  // Converter resolution and full scale in millivolts.
  localparam int CODE_BITS     = 12;
  localparam int FULL_SCALE_MV = 3300;

  // Field widths of the command and of the frame.
  localparam int VALUE_W      = 12;
  localparam int CHANNEL_W    = 3;
  localparam int FRAME_W      = 16;
  localparam int FRAME_CODE_W = 12;
  localparam int POS_W        = 4;

  // Scaled product mv * (2^CODE_BITS - 1) and the reciprocal multiplier of full scale.
  localparam int PROD_W  = VALUE_W + CODE_BITS;
  localparam int FS_W    = 13;
  localparam int RECIP_W = PROD_W - 9;
  localparam int RECIP   = (1 << PROD_W) / FULL_SCALE_MV;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FRAME_W-1:0] FRAME_MODE_THROUGH  = 16'h9000;
  localparam logic [FRAME_W-1:0] FRAME_MODE_REGISTER = 16'h8000;

  typedef enum logic [1:0] {
    ACT_SET_MV        = 2'd0,
    ACT_SET_CODE      = 2'd1,
    ACT_MODE_THROUGH  = 2'd2,
    ACT_MODE_REGISTER = 2'd3
  } action_e;

  typedef logic [FRAME_W-1:0] frame_t;

endpackage

`default_nettype wire

[rtl/dsfw_if.sv]
// Channel interfaces of the DAC serial frame writer: command, frame, result bit.
// Depends on dsfw_pkg.
`default_nettype none

interface dsfw_cmd_if;
  import dsfw_pkg::*;
  logic                 valid;
  logic                 ready;
  action_e              action;
  logic [CHANNEL_W-1:0] channel;
  logic [VALUE_W-1:0]   value;
  modport source (output valid, action, channel, value, input ready);
  modport sink   (input valid, action, channel, value, output ready);
endinterface

interface dsfw_frame_if;
  import dsfw_pkg::*;
  logic   valid;
  logic   ready;
  frame_t frame;
  modport source (output valid, frame, input ready);
  modport sink   (input valid, frame, output ready);
endinterface

interface dsfw_bit_if;
  import dsfw_pkg::*;
  logic             valid;
  logic             ready;
  logic             data_bit;
  logic [POS_W-1:0] bit_position;
  logic             last_bit;
  modport source (output valid, data_bit, bit_position, last_bit, input ready);
  modport sink   (input valid, data_bit, bit_position, last_bit, output ready);
endinterface

`default_nettype wire

[rtl/dac_spi_frame_writer_top.sv]
// Top level of the DAC serial frame writer: front end, frame queue, back end.
// Depends on dsfw_pkg, dsfw_if, dsfw_front, dsfw_queue, dsfw_back.
//
// Usage:
//   cmd_i takes one command item (action, channel, value). Set-voltage turns
//   millivolts into floor(mv * 4095 / 3300), saturated at full scale; set-code
//   sends the low code bits raw; the two mode commands send fixed frames.
//   bit_o gives 16 result items per command, bit 15 first, last_bit on bit 0.
//   Path: when the back end is free, the first bit of a frame becomes valid
//   once its accepted command has passed the second front stage, the queue
//   and the shift register. Throughput: the back-end shift register emits one
//   bit per cycle while bit_o is ready; frames follow one another with no gap.
//   The front end takes commands back to back until its two stages and the
//   two-entry queue are full, so up to four commands are absorbed
//   while a frame is shifting.
//   When the receiver stalls bit_o, the current bit holds and the queue and
//   front stages fill, then cmd_i.ready drops.
//   Reset (rst_ni low, asynchronous) empties the pipeline, the queue and the
//   shift register; no items are in flight afterwards.
`default_nettype none

module dac_spi_frame_writer_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  dsfw_cmd_if.sink    cmd_i,
  dsfw_bit_if.source  bit_o
);
  import dsfw_pkg::*;

  dsfw_frame_if front_to_queue ();
  dsfw_frame_if queue_to_back ();

  dsfw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .frame_o (front_to_queue)
  );

  dsfw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_to_queue),
    .out_o  (queue_to_back)
  );

  dsfw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (queue_to_back),
    .bit_o   (bit_o)
  );

  // Bits of a frame count down one by one.
  a_pos_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_o.valid && bit_o.ready && bit_o.bit_position != '0) |=>
      (bit_o.valid && bit_o.bit_position == $past(bit_o.bit_position) - 1'b1))
    else $error("bit position did not step down");

  // A new frame always starts at its top bit.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_o.valid && bit_o.ready && bit_o.last_bit) |=>
      (!bit_o.valid || bit_o.bit_position == POS_W'(FRAME_W - 1)))
    else $error("frame did not start at top bit");

  // A frame with bit 15 set is a mode frame with empty low bits.
  a_mode_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_to_queue.valid && front_to_queue.frame[FRAME_W-1]) |->
      (front_to_queue.frame[FRAME_W-2:FRAME_W-3] == 2'b00 &&
       front_to_queue.frame[FRAME_CODE_W-1:0] == '0))
    else $error("malformed mode frame");

endmodule

`default_nettype wire

[rtl/dsfw_front.sv]
// Front end: accepts commands and builds the 16-bit frame in a short pipeline
// (scale, reciprocal multiply, remainder fix-up). Depends on dsfw_pkg, dsfw_if.
`default_nettype none

module dsfw_front (
  input  wire           clk_i,
  input  wire           rst_ni,
  dsfw_cmd_if.sink      cmd_i,
  dsfw_frame_if.source  frame_o
);
  import dsfw_pkg::*;

  localparam logic [CODE_BITS-1:0] CODE_MAX = {CODE_BITS{1'b1}};
  localparam logic [FS_W-1:0]      FS       = FS_W'(FULL_SCALE_MV);

  // stage 1: scaled product
  logic                 s1_valid_q;
  action_e              s1_action_q;
  logic [CHANNEL_W-1:0] s1_channel_q;
  logic [VALUE_W-1:0]   s1_value_q;
  logic [PROD_W-1:0]    s1_prod_q;
  logic                 s1_sat_q;

  // stage 2: quotient estimate, at most one low
  logic                 s2_valid_q;
  action_e              s2_action_q;
  logic [CHANNEL_W-1:0] s2_channel_q;
  logic [VALUE_W-1:0]   s2_value_q;
  logic [PROD_W-1:0]    s2_prod_q;
  logic                 s2_sat_q;
  logic [CODE_BITS-1:0] s2_qest_q;

  logic s1_en, s2_en;
  logic [PROD_W-1:0]         prod_d;
  logic                      sat_d;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [CODE_BITS+FS_W-1:0] qfs;
  logic [CODE_BITS+FS_W-1:0] rem;
  logic [CODE_BITS-1:0]      quot;
  logic [CODE_BITS-1:0]      code;

  assign s2_en       = !s2_valid_q || frame_o.ready;
  assign s1_en       = !s1_valid_q || s2_en;
  assign cmd_i.ready = s1_en;

  // mv * (2^n - 1) as a shift and subtract
  assign prod_d = PROD_W'({cmd_i.value, {CODE_BITS{1'b0}}}) - PROD_W'(cmd_i.value);
  assign sat_d  = {1'b0, cmd_i.value} > FS;

  assign recip_prod = s1_prod_q * RECIP_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= cmd_i.valid;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && cmd_i.valid) begin
      s1_action_q  <= cmd_i.action;
      s1_channel_q <= cmd_i.channel;
      s1_value_q   <= cmd_i.value;
      s1_prod_q    <= prod_d;
      s1_sat_q     <= sat_d;
    end
    if (s2_en && s1_valid_q) begin
      s2_action_q  <= s1_action_q;
      s2_channel_q <= s1_channel_q;
      s2_value_q   <= s1_value_q;
      s2_prod_q    <= s1_prod_q;
      s2_sat_q     <= s1_sat_q;
      s2_qest_q    <= recip_prod[PROD_W +: CODE_BITS];
    end
  end

  // remainder below twice full scale: one conditional increment
  assign qfs  = s2_qest_q * FS;
  assign rem  = (CODE_BITS+FS_W)'(s2_prod_q) - qfs;
  assign quot = (rem >= (CODE_BITS+FS_W)'(FS)) ? s2_qest_q + 1'b1 : s2_qest_q;
  assign code = s2_sat_q ? CODE_MAX : quot;

  always_comb begin
    case (s2_action_q)
      ACT_SET_MV:
        frame_o.frame = {1'b0, s2_channel_q, FRAME_CODE_W'(code)};
      ACT_SET_CODE:
        frame_o.frame = {1'b0, s2_channel_q, FRAME_CODE_W'(s2_value_q[CODE_BITS-1:0])};
      ACT_MODE_THROUGH:  frame_o.frame = FRAME_MODE_THROUGH;
      ACT_MODE_REGISTER: frame_o.frame = FRAME_MODE_REGISTER;
      default:           frame_o.frame = FRAME_MODE_REGISTER;
    endcase
  end

  assign frame_o.valid = s2_valid_q;

endmodule

`default_nettype wire

[rtl/dsfw_queue.sv]
// Short frame queue between front and back ends.
// Depends on dsfw_pkg, dsfw_if.
`default_nettype none

module dsfw_queue (
  input  wire          clk_i,
  input  wire          rst_ni,
  dsfw_frame_if.sink   in_i,
  dsfw_frame_if.source out_o
);
  import dsfw_pkg::*;

  frame_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                push, pop;

  assign in_i.ready  = count_q != QCNT_W'(QUEUE_DEPTH);
  assign out_o.valid = count_q != '0;
  assign out_o.frame = mem_q[rd_ptr_q];
  assign push = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_i.frame;
  end

endmodule

`default_nettype wire

[rtl/dsfw_back.sv]
// Back end: shifts one frame out MSB first, one result item per bit.
// Depends on dsfw_pkg, dsfw_if.
`default_nettype none

module dsfw_back (
  input  wire         clk_i,
  input  wire         rst_ni,
  dsfw_frame_if.sink  frame_i,
  dsfw_bit_if.source  bit_o
);
  import dsfw_pkg::*;

  logic             busy_q;
  frame_t           frame_q;
  logic [POS_W-1:0] pos_q;
  logic             out_acc;

  assign out_acc       = bit_o.valid && bit_o.ready;
  // reload straight after the last bit so frames run without a gap
  assign frame_i.ready = !busy_q || (out_acc && pos_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (out_acc && pos_q != '0) begin
      pos_q <= pos_q - 1'b1;
    end else if (frame_i.ready) begin
      busy_q <= frame_i.valid;
      if (frame_i.valid) pos_q <= POS_W'(FRAME_W - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.ready && frame_i.valid) frame_q <= frame_i.frame;
  end

  assign bit_o.valid        = busy_q;
  assign bit_o.data_bit     = frame_q[pos_q];
  assign bit_o.bit_position = pos_q;
  assign bit_o.last_bit     = pos_q == '0;

endmodule

`default_nettype wire

[sim/dac_spi_frame_writer_top_test.sv]
// Self-checking bench for dac_spi_frame_writer_top: a directed command table, then random
// commands. Each expected frame is queued bit by bit and checked on the serial output.
// Depends on dsfw_pkg, dsfw_if and the RTL of dac_spi_frame_writer_top.
`default_nettype none

module dac_spi_frame_writer_top_test;
  import dsfw_pkg::*;

  localparam int RAND_ITEMS  = 400;
  localparam int QUIET_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the pipeline
  localparam int DRAIN_WAIT  = 20;    // wait after the last bit, longer than the first-bit latency

  typedef struct packed {
    logic             data_bit;
    logic [POS_W-1:0] bit_position;
    logic             last_bit;
  } frame_bit_t;

  // One command row; frame is only used where known is set.
  typedef struct {
    action_e              act;
    logic [CHANNEL_W-1:0] ch;
    logic [VALUE_W-1:0]   val;
    bit                   known;
    frame_t               frame;
  } cmd_row_t;

  localparam int NUM_DIR = 22;

  cmd_row_t dir_rows [NUM_DIR] = '{
    '{ACT_SET_MV,        3'd0, 12'd0,     1'b1, 16'h0000},  // zero volts
    '{ACT_SET_MV,        3'd7, 12'd3300,  1'b1, 16'h7FFF},  // exactly full scale
    '{ACT_SET_MV,        3'd3, 12'd4095,  1'b1, 16'h3FFF},  // saturates
    '{ACT_SET_MV,        3'd1, 12'd3301,  1'b1, 16'h1FFF},  // just above full scale
    '{ACT_SET_MV,        3'd2, 12'd1,     1'b1, 16'h2001},
    '{ACT_SET_MV,        3'd5, 12'd3299,  1'b1, 16'h5FFD},  // floor, no rounding up
    '{ACT_SET_MV,        3'd4, 12'd1650,  1'b0, 16'h0000},
    '{ACT_SET_MV,        3'd6, 12'd2048,  1'b0, 16'h0000},
    '{ACT_SET_CODE,      3'd0, 12'd0,     1'b1, 16'h0000},
    '{ACT_SET_CODE,      3'd7, 12'hFFF,   1'b1, 16'h7FFF},
    '{ACT_SET_CODE,      3'd2, 12'hABC,   1'b0, 16'h0000},
    '{ACT_SET_CODE,      3'd5, 12'h555,   1'b0, 16'h0000},
    '{ACT_SET_CODE,      3'd1, 12'h800,   1'b0, 16'h0000},
    '{ACT_MODE_THROUGH,  3'd0, 12'd0,     1'b1, 16'h9000},
    '{ACT_MODE_THROUGH,  3'd7, 12'hFFF,   1'b1, 16'h9000},  // channel, value ignored
    '{ACT_MODE_REGISTER, 3'd0, 12'd0,     1'b1, 16'h8000},
    '{ACT_MODE_REGISTER, 3'd7, 12'hFFF,   1'b1, 16'h8000},
    '{ACT_MODE_THROUGH,  3'd5, 12'h123,   1'b0, 16'h0000},
    '{ACT_SET_MV,        3'd7, 12'h7FF,   1'b0, 16'h0000},
    '{ACT_SET_CODE,      3'd3, 12'h7FF,   1'b0, 16'h0000},
    '{ACT_SET_MV,        3'd0, 12'd3300,  1'b1, 16'h0FFF},
    '{ACT_MODE_REGISTER, 3'd2, 12'h5A5,   1'b0, 16'h0000}
  };

  logic clk;
  logic rst_n;

  dsfw_cmd_if cmd_if ();
  dsfw_bit_if bit_if ();

  dac_spi_frame_writer_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .bit_o  (bit_if)
  );

  frame_bit_t bits_due [$];
  int         errors         = 0;
  int         send_idle_pct  = 10;
  int         recv_stall_pct = 66;
  bit         hold_req       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Frame for one command: channel over the 12-bit code, or a fixed mode frame.
  function automatic frame_t predict_frame(action_e act, logic [CHANNEL_W-1:0] ch,
                                           logic [VALUE_W-1:0] val);
    int unsigned top;
    int unsigned code;
    top = (32'd1 << CODE_BITS) - 32'd1;
    case (act)
      ACT_SET_MV: begin
        if (32'(val) > 32'(FULL_SCALE_MV)) code = top;
        else code = (32'(val) * top) / 32'(FULL_SCALE_MV);
      end
      ACT_SET_CODE: begin
        code = 32'(val) & top;
      end
      ACT_MODE_THROUGH: begin
        return FRAME_MODE_THROUGH;
      end
      default: begin
        return FRAME_MODE_REGISTER;
      end
    endcase
    code = code & ((32'd1 << FRAME_CODE_W) - 32'd1);
    return frame_t'((32'(ch) << FRAME_CODE_W) | code);
  endfunction

  // Offer one command, with random idle cycles ahead of it; returns once accepted.
  // valid is left high so a following command goes out back to back.
  task automatic send_cmd(action_e act, logic [CHANNEL_W-1:0] ch,
                          logic [VALUE_W-1:0] val, frame_t frame);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.action  <= act;
    cmd_if.channel <= ch;
    cmd_if.value   <= val;
    do @(posedge clk); while (!cmd_if.ready);
    // MSB first, last marker on bit 0
    for (int p = FRAME_W - 1; p >= 0; p--) begin
      bits_due.push_back({frame[p], POS_W'(p), (p == 0)});
    end
  endtask

  // Receiver: checks each accepted bit item, drives ready with random stalls
  // and serves the long hold-off request.
  initial begin : bit_receiver
    frame_bit_t got;
    frame_bit_t want;
    int         hold_left;
    hold_left    = 0;
    bit_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (bit_if.valid && bit_if.ready) begin
        got = {bit_if.data_bit, bit_if.bit_position, bit_if.last_bit};
        if (bits_due.size() == 0) begin
          $display("%0t: bit item with nothing expected: data %b pos %0d last %b",
                   $time, got.data_bit, got.bit_position, got.last_bit);
          errors++;
        end else begin
          want = bits_due.pop_front();
          if (got.data_bit !== want.data_bit || got.bit_position !== want.bit_position ||
              got.last_bit !== want.last_bit) begin
            $display("%0t: bit mismatch: expected %b pos %0d last %b, got %b pos %0d last %b",
                     $time, want.data_bit, want.bit_position, want.last_bit,
                     got.data_bit, got.bit_position, got.last_bit);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        bit_if.ready <= 1'b0;
      end else begin
        bit_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (bit_if.valid && bit_if.ready)) quiet = 0;
      else if (rst_n) quiet++;
    end
    $display("** dac_spi_frame_writer_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    cmd_row_t             row;
    frame_t               frame;
    action_e              act;
    logic [CHANNEL_W-1:0] ch;
    logic [VALUE_W-1:0]   val;
    cmd_if.valid   = 1'b0;
    cmd_if.action  = ACT_SET_MV;
    cmd_if.channel = '0;
    cmd_if.value   = '0;
    @(posedge rst_n);
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row   = dir_rows[i];
      frame = row.known ? row.frame : predict_frame(row.act, row.ch, row.val);
      send_cmd(row.act, row.ch, row.val, frame);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 130) begin
        send_idle_pct  = 66;
        recv_stall_pct = 10;
      end
      if (n == 260) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // sender pause until every queued bit has come out
      if (n == 200) begin
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (bits_due.size() != 0);
      end
      // receiver holds off while commands keep coming; input must back up
      if (n == 300) hold_req = 1'b1;

      act = action_e'($urandom_range(0, 3));
      ch  = CHANNEL_W'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       val = VALUE_W'($urandom_range(FULL_SCALE_MV + 1, 4095));
        1: begin
          case ($urandom_range(0, 2))
            0:       val = '0;
            1:       val = VALUE_W'(FULL_SCALE_MV);
            default: val = '1;
          endcase
        end
        default: val = VALUE_W'($urandom_range(0, 4095));
      endcase
      send_cmd(act, ch, val, predict_frame(act, ch, val));
    end

    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (bits_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && bits_due.size() == 0) begin
      $display("** dac_spi_frame_writer_top: PASSED **");
    end else begin
      $display("** dac_spi_frame_writer_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
